// ----- hw/rtl/binary_min_heap_top_assert.svh -----
// Assertion macros for the binary min-heap.
`ifndef BINARY_MIN_HEAP_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_TOP_ASSERT_SVH

// Check that an expression holds at every clock edge outside reset.
`define BMH_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition is followed by a consequence in the next clock cycle.
`define BMH_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bmh_pkg.sv -----
`timescale 1ns / 1ps

package bmh_pkg;

   localparam int KEY_W        = 32;
   localparam int OCC_W        = 7;
   localparam int CAPACITY_DEF = 64;
   localparam int PC_W         = 4;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_PEEK   = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // datapath operation of one microcode step
   typedef enum logic [3:0] {
      UOP_IDLE,
      UOP_UP_INIT,
      UOP_UP_RD,
      UOP_UP_CMP,
      UOP_PLACE,
      UOP_DN_ROOT,
      UOP_DN_LAST,
      UOP_DN_INIT,
      UOP_DN_LEFT,
      UOP_DN_RIGHT,
      UOP_DN_CMP,
      UOP_PK_RD,
      UOP_PK_LATCH,
      UOP_NOP,
      UOP_FINISH
   } uop_type;

   // jump condition: taken jumps to target, otherwise step to pc + 1 (dispatch enters the handler or holds)
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_POS_ZERO,
      COND_UP_MOVE,
      COND_NO_LEFT,
      COND_DN_MOVE,
      COND_RSP_BUSY
   } cond_type;

   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      pc_type   target;
   } ctrl_type;

   typedef struct packed {
      logic   go;
      pc_type disp_pc;
      logic   pos_zero;
      logic   up_move;
      logic   no_left;
      logic   dn_move;
      logic   rsp_busy;
   } flags_type;

   // step addresses
   localparam pc_type PC_IDLE     = 4'd0;
   localparam pc_type PC_UP_INIT  = 4'd1;
   localparam pc_type PC_UP_RD    = 4'd2;
   localparam pc_type PC_UP_CMP   = 4'd3;
   localparam pc_type PC_UP_PLACE = 4'd4;
   localparam pc_type PC_DN_ROOT  = 4'd5;
   localparam pc_type PC_DN_LAST  = 4'd6;
   localparam pc_type PC_DN_INIT  = 4'd7;
   localparam pc_type PC_DN_LEFT  = 4'd8;
   localparam pc_type PC_DN_RIGHT = 4'd9;
   localparam pc_type PC_DN_CMP   = 4'd10;
   localparam pc_type PC_DN_PLACE = 4'd11;
   localparam pc_type PC_PK_RD    = 4'd12;
   localparam pc_type PC_PK_LATCH = 4'd13;
   localparam pc_type PC_SPARE    = 4'd14;
   localparam pc_type PC_FINISH   = 4'd15;

   // microcode store
   function automatic ctrl_type ucode(input pc_type pc);
      ctrl_type cw;
      unique case (pc)
         PC_IDLE:     cw = '{UOP_IDLE,     COND_DISPATCH, PC_IDLE};
         PC_UP_INIT:  cw = '{UOP_UP_INIT,  COND_NEXT,     PC_IDLE};
         PC_UP_RD:    cw = '{UOP_UP_RD,    COND_POS_ZERO, PC_UP_PLACE};
         PC_UP_CMP:   cw = '{UOP_UP_CMP,   COND_UP_MOVE,  PC_UP_RD};
         PC_UP_PLACE: cw = '{UOP_PLACE,    COND_ALWAYS,   PC_FINISH};
         PC_DN_ROOT:  cw = '{UOP_DN_ROOT,  COND_NEXT,     PC_IDLE};
         PC_DN_LAST:  cw = '{UOP_DN_LAST,  COND_NEXT,     PC_IDLE};
         PC_DN_INIT:  cw = '{UOP_DN_INIT,  COND_NEXT,     PC_IDLE};
         PC_DN_LEFT:  cw = '{UOP_DN_LEFT,  COND_NO_LEFT,  PC_DN_PLACE};
         PC_DN_RIGHT: cw = '{UOP_DN_RIGHT, COND_NEXT,     PC_IDLE};
         PC_DN_CMP:   cw = '{UOP_DN_CMP,   COND_DN_MOVE,  PC_DN_LEFT};
         PC_DN_PLACE: cw = '{UOP_PLACE,    COND_ALWAYS,   PC_FINISH};
         PC_PK_RD:    cw = '{UOP_PK_RD,    COND_NEXT,     PC_IDLE};
         PC_PK_LATCH: cw = '{UOP_PK_LATCH, COND_ALWAYS,   PC_FINISH};
         PC_SPARE:    cw = '{UOP_NOP,      COND_ALWAYS,   PC_IDLE};
         PC_FINISH:   cw = '{UOP_FINISH,   COND_RSP_BUSY, PC_FINISH};
      endcase
      return cw;
   endfunction

endpackage

// ----- hw/rtl/bmh_req_if.sv -----
`timescale 1ns / 1ps

interface bmh_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         action;
   logic signed [bmh_pkg::KEY_W-1:0]   key_in;

   modport source (output valid, output action, output key_in, input ready);
   modport sink   (input valid, input action, input key_in, output ready);
endinterface

// ----- hw/rtl/bmh_rsp_if.sv -----
`timescale 1ns / 1ps

interface bmh_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bmh_pkg::KEY_W-1:0]   key_out;
   logic [1:0]                         status;
   logic [bmh_pkg::OCC_W-1:0]          occupancy;

   modport source (output valid, output key_out, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input key_out, input status, input occupancy,
                   output ready);
endinterface

// ----- hw/rtl/bmh_ram.sv -----
`timescale 1ns / 1ps

module bmh_ram #(
   parameter int DEPTH = bmh_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(bmh_pkg::CAPACITY_DEF)
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [AW-1:0]                    wr_addr,
   input  logic signed [bmh_pkg::KEY_W-1:0] wr_data,
   input  logic [AW-1:0]                    rd_addr,
   output logic signed [bmh_pkg::KEY_W-1:0] rd_data
);

   logic signed [bmh_pkg::KEY_W-1:0] mem [DEPTH];
   logic signed [bmh_pkg::KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bmh_seq.sv -----
`timescale 1ns / 1ps

module bmh_seq (
   input  logic                clock,
   input  logic                reset,
   input  bmh_pkg::flags_type  flags,
   output bmh_pkg::ctrl_type   ctrl
);

   bmh_pkg::pc_type pc_ff;
   bmh_pkg::pc_type pc_in;
   logic            taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bmh_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      ctrl  = bmh_pkg::ucode(pc_ff);
      taken = 1'b0;
      unique case (ctrl.cond)
         bmh_pkg::COND_NEXT:     taken = 1'b0;
         bmh_pkg::COND_ALWAYS:   taken = 1'b1;
         bmh_pkg::COND_DISPATCH: taken = 1'b1;
         bmh_pkg::COND_POS_ZERO: taken = flags.pos_zero;
         bmh_pkg::COND_UP_MOVE:  taken = flags.up_move;
         bmh_pkg::COND_NO_LEFT:  taken = flags.no_left;
         bmh_pkg::COND_DN_MOVE:  taken = flags.dn_move;
         bmh_pkg::COND_RSP_BUSY: taken = flags.rsp_busy;
         default:                taken = 1'b0;
      endcase
      // dispatch: hold while no item waits, else enter the handler
      priority if (ctrl.cond == bmh_pkg::COND_DISPATCH) begin
         pc_in = flags.go ? flags.disp_pc : pc_ff;
      end else if (taken) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + bmh_pkg::pc_type'(1);
      end
   end

endmodule

// ----- hw/rtl/binary_min_heap_top.sv -----
`timescale 1ns / 1ps

// Binary min-heap priority queue of signed 32-bit keys, one operation per item: insert,
// remove the minimum or peek at the minimum. Every item yields one result with the key
// removed or peeked (zero otherwise), a status (ok, empty, full) and the occupancy after
// the operation. Items are handled one at a time by a 16-step microcode program driving a
// datapath around a key memory with one write port and one registered read port. An
// insert spends a read-then-compare pair of steps per level and a remove spends three
// steps per level (left read, right read, compare). A finished result sits in an output
// register, so the next item is taken while it waits; only the final step stalls when
// that register is still full. The heap starts empty after reset and needs no clearing
// pass.

`include "binary_min_heap_top_assert.svh"

module binary_min_heap_top #(
   parameter int CAPACITY = bmh_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bmh_req_if.sink     req_chan,
   bmh_rsp_if.source   rsp_chan
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;
   localparam int KW = bmh_pkg::KEY_W;

   bmh_pkg::ctrl_type  ctrl;
   bmh_pkg::flags_type flags;

   // datapath registers
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic signed [KW-1:0]   key_ff, key_in;
   logic signed [KW-1:0]   left_ff, left_in;
   logic signed [KW-1:0]   kout_ff, kout_in;
   bmh_pkg::status_type    status_ff, status_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [KW-1:0]   rsp_key_ff, rsp_key_in;
   bmh_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [bmh_pkg::OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   // memory port
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic signed [KW-1:0]   wr_data;
   logic [AW-1:0]          rd_addr;
   logic signed [KW-1:0]   rd_data;

   // index and compare logic
   logic                   accept;
   logic                   is_full, is_empty;
   logic [AW-1:0]          parent_idx;
   logic [IW-1:0]          left_idx, right_idx, cnt_wide;
   logic                   right_ok, take_right;
   logic signed [KW-1:0]   pick_val;
   logic [AW-1:0]          pick_idx;
   bmh_pkg::status_type    acc_status;
   bmh_pkg::pc_type        acc_pc;

   // step decode used by the checks at the end
   logic                   in_idle, in_finish, fin_free;

   bmh_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   bmh_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign in_idle   = (ctrl.uop == bmh_pkg::UOP_IDLE);
   assign in_finish = (ctrl.uop == bmh_pkg::UOP_FINISH);
   assign fin_free  = in_finish && !flags.rsp_busy;

   // take a new item only in the idle step
   assign req_chan.ready = in_idle;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_full    = (cnt_ff == CW'(CAPACITY));
   assign is_empty   = (cnt_ff == '0);
   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + IW'(1);
   assign cnt_wide   = IW'(cnt_ff);

   // pick the right child only when it exists and is strictly smaller
   assign right_ok   = (right_idx < cnt_wide);
   assign take_right = right_ok && (rd_data < left_ff);
   assign pick_val   = take_right ? rd_data : left_ff;
   assign pick_idx   = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

   // status and handler entry for the arriving item
   always_comb begin
      acc_status = bmh_pkg::ST_OK;
      acc_pc     = bmh_pkg::PC_FINISH;
      unique case (req_chan.action)
         bmh_pkg::ACT_INSERT: begin
            if (is_full) begin
               acc_status = bmh_pkg::ST_FULL;
            end else begin
               acc_pc = bmh_pkg::PC_UP_INIT;
            end
         end
         bmh_pkg::ACT_REMOVE: begin
            if (is_empty) begin
               acc_status = bmh_pkg::ST_EMPTY;
            end else begin
               acc_pc = bmh_pkg::PC_DN_ROOT;
            end
         end
         bmh_pkg::ACT_PEEK: begin
            if (is_empty) begin
               acc_status = bmh_pkg::ST_EMPTY;
            end else begin
               acc_pc = bmh_pkg::PC_PK_RD;
            end
         end
         default: begin
            // unused code: report ok and leave the heap alone
            acc_status = bmh_pkg::ST_OK;
            acc_pc     = bmh_pkg::PC_FINISH;
         end
      endcase
   end

   // jump conditions for the sequencer
   always_comb begin
      flags.go       = req_chan.valid;
      flags.disp_pc  = acc_pc;
      flags.pos_zero = (pos_ff == '0);
      flags.up_move  = (key_ff < rd_data);
      flags.no_left  = (left_idx >= cnt_wide);
      flags.dn_move  = (pick_val < key_ff);
      flags.rsp_busy = rsp_valid_ff && !rsp_chan.ready;
   end

   // datapath controlled by the current microcode step
   always_comb begin
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      left_in   = left_ff;
      kout_in   = kout_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = key_ff;
      rd_addr   = '0;

      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      // drop the result once taken
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      unique case (ctrl.uop)
         bmh_pkg::UOP_IDLE: begin
            if (accept) begin
               key_in    = req_chan.key_in;
               kout_in   = '0;
               status_in = acc_status;
            end
         end
         bmh_pkg::UOP_UP_INIT: begin
            // open a hole at the end of the heap
            pos_in = AW'(cnt_ff);
            cnt_in = cnt_ff + CW'(1);
         end
         bmh_pkg::UOP_UP_RD: begin
            rd_addr = parent_idx;
         end
         bmh_pkg::UOP_UP_CMP: begin
            // move the parent down into the hole and climb
            if (flags.up_move) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = parent_idx;
            end
         end
         bmh_pkg::UOP_PLACE: begin
            wr_en   = 1'b1;
            wr_data = key_ff;
         end
         bmh_pkg::UOP_DN_ROOT: begin
            rd_addr = '0;
            cnt_in  = cnt_ff - CW'(1);
         end
         bmh_pkg::UOP_DN_LAST: begin
            kout_in = rd_data;
            rd_addr = AW'(cnt_ff);
         end
         bmh_pkg::UOP_DN_INIT: begin
            // last entry becomes the key that sinks from the root
            key_in = rd_data;
            pos_in = '0;
         end
         bmh_pkg::UOP_DN_LEFT: begin
            rd_addr = left_idx[AW-1:0];
         end
         bmh_pkg::UOP_DN_RIGHT: begin
            left_in = rd_data;
            rd_addr = right_idx[AW-1:0];
         end
         bmh_pkg::UOP_DN_CMP: begin
            // lift the smaller child into the hole and sink
            if (flags.dn_move) begin
               wr_en   = 1'b1;
               wr_data = pick_val;
               pos_in  = pick_idx;
            end
         end
         bmh_pkg::UOP_PK_RD: begin
            rd_addr = '0;
         end
         bmh_pkg::UOP_PK_LATCH: begin
            kout_in = rd_data;
         end
         bmh_pkg::UOP_NOP: begin
            wr_en = 1'b0;
         end
         bmh_pkg::UOP_FINISH: begin
            if (!flags.rsp_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_key_in    = kout_ff;
               rsp_status_in = status_ff;
               rsp_occ_in    = bmh_pkg::OCC_W'(cnt_ff);
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      left_ff       <= left_in;
      kout_ff       <= kout_in;
      status_ff     <= status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.key_out   = rsp_key_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.occupancy = rsp_occ_ff;

   // occupancy never passes the capacity
   `BMH_ASSERT_ALWAYS(a_cnt_range, clock, reset, cnt_ff <= CW'(CAPACITY), "count overflow")
   // an accepted item always leaves the idle step
   `BMH_ASSERT_NEXT(a_dispatch, clock, reset, accept, !in_idle, "item not dispatched")
   // a final step with a free output register presents a result
   `BMH_ASSERT_NEXT(a_finish, clock, reset, fin_free, rsp_valid_ff && in_idle, "no result")
   // memory writes happen only inside an item's program
   `BMH_ASSERT_ALWAYS(a_wr_busy, clock, reset, !wr_en || !(in_idle || in_finish), "stray write")

endmodule

// ----- dv/tb_binary_min_heap_top.sv -----
`timescale 1ns / 1ps

module tb_binary_min_heap_top;

   localparam int KEY_W         = bmh_pkg::KEY_W;
   localparam int OCC_W         = bmh_pkg::OCC_W;
   localparam int HEAP_DEPTH    = bmh_pkg::CAPACITY_DEF;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 25;

   // one result as it should leave the block
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      bmh_pkg::status_type     status;
      logic [OCC_W-1:0]        occ;
   } heap_result_type;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct packed {
      bmh_pkg::action_type     op;
      logic signed [KEY_W-1:0] key;
      bit                      typed;
      heap_result_type         rsp;
   } heap_vector_type;

   // traffic shape of the random part
   typedef enum logic [1:0] {
      LOAD_FILL,
      LOAD_DRAIN,
      LOAD_MIXED
   } load_mode_type;

   logic clock = 1'b0;
   logic reset;

   bmh_req_if req_chan ();
   bmh_rsp_if rsp_chan ();

   binary_min_heap_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow heap: keys held in array order plus the number of keys held
   logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
   int                      heap_size;

   // results still owed by the block, oldest first
   heap_result_type         heap_rsp_q [$];

   int             mismatch_count;
   int             cycle_count;
   int             burst_left;
   int             stall_left;
   int             ready_phase;
   load_mode_type  load_mode;
   int             mixed_left;

   // Directed table: empty-heap errors, the unused action code, both key
   // extremes, duplicate keys and a full drain back to empty. Rows that need
   // the heap order worked out are left to the shadow heap.
   heap_vector_type directed_ops [DIRECTED_ROWS] = '{
      '{bmh_pkg::ACT_PEEK,   32'sd5,         1'b1, '{32'sd0,         bmh_pkg::ST_EMPTY, 7'd0}},
      '{bmh_pkg::ACT_REMOVE, 32'sd0,         1'b1, '{32'sd0,         bmh_pkg::ST_EMPTY, 7'd0}},
      '{bmh_pkg::ACT_NOP,    32'shFFFF_FFFF, 1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd0}},
      '{bmh_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd1}},
      '{bmh_pkg::ACT_PEEK,   32'sd0,         1'b1, '{32'sh7FFF_FFFF, bmh_pkg::ST_OK,    7'd1}},
      '{bmh_pkg::ACT_INSERT, 32'sh8000_0000, 1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd2}},
      '{bmh_pkg::ACT_PEEK,   32'sd0,         1'b1, '{32'sh8000_0000, bmh_pkg::ST_OK,    7'd2}},
      '{bmh_pkg::ACT_INSERT, 32'sd0,         1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd3}},
      '{bmh_pkg::ACT_INSERT, 32'shFFFF_FFFF, 1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd4}},
      '{bmh_pkg::ACT_INSERT, 32'sd1,         1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd5}},
      '{bmh_pkg::ACT_INSERT, 32'sd0,         1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd6}},
      '{bmh_pkg::ACT_INSERT, 32'sh8000_0000, 1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd7}},
      '{bmh_pkg::ACT_NOP,    32'sh7FFF_FFFF, 1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd7}},
      '{bmh_pkg::ACT_REMOVE, 32'sd0,         1'b1, '{32'sh8000_0000, bmh_pkg::ST_OK,    7'd6}},
      '{bmh_pkg::ACT_REMOVE, 32'sd0,         1'b1, '{32'sh8000_0000, bmh_pkg::ST_OK,    7'd5}},
      '{bmh_pkg::ACT_REMOVE, 32'sd0,         1'b0, '0},
      '{bmh_pkg::ACT_PEEK,   32'sd0,         1'b0, '0},
      '{bmh_pkg::ACT_REMOVE, 32'sd0,         1'b0, '0},
      '{bmh_pkg::ACT_REMOVE, 32'sd0,         1'b0, '0},
      '{bmh_pkg::ACT_REMOVE, 32'sd0,         1'b0, '0},
      '{bmh_pkg::ACT_REMOVE, 32'sd0,         1'b0, '0},
      '{bmh_pkg::ACT_REMOVE, 32'sd0,         1'b1, '{32'sd0,         bmh_pkg::ST_EMPTY, 7'd0}},
      '{bmh_pkg::ACT_INSERT, 32'sh5555_5555, 1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd1}},
      '{bmh_pkg::ACT_INSERT, 32'shAAAA_AAAA, 1'b1, '{32'sd0,         bmh_pkg::ST_OK,    7'd2}},
      '{bmh_pkg::ACT_PEEK,   32'sd0,         1'b0, '0}
   };

   // Apply one operation to the shadow heap and return the result it owes.
   // Sift up while strictly smaller than the parent; sift down takes the
   // right child only when it is strictly smaller than the left one.
   function automatic heap_result_type apply_heap_op(input bmh_pkg::action_type op,
                                                     input logic signed [KEY_W-1:0] key);
      heap_result_type         rsp;
      int                      pos;
      int                      up;
      int                      lft;
      int                      pick;
      logic signed [KEY_W-1:0] held;
      rsp.key    = '0;
      rsp.status = bmh_pkg::ST_OK;
      case (op)
         bmh_pkg::ACT_INSERT: begin
            if (heap_size >= HEAP_DEPTH) begin
               rsp.status = bmh_pkg::ST_FULL;
            end else begin
               pos = heap_size;
               heap_keys[pos] = key;
               heap_size++;
               while (pos > 0) begin
                  up = (pos - 1) / 2;
                  if (!(heap_keys[pos] < heap_keys[up])) break;
                  held           = heap_keys[pos];
                  heap_keys[pos] = heap_keys[up];
                  heap_keys[up]  = held;
                  pos            = up;
               end
            end
         end
         bmh_pkg::ACT_REMOVE: begin
            if (heap_size == 0) begin
               rsp.status = bmh_pkg::ST_EMPTY;
            end else begin
               rsp.key = heap_keys[0];
               heap_size--;
               heap_keys[0] = heap_keys[heap_size];
               pos = 0;
               forever begin
                  lft = 2 * pos + 1;
                  if (lft >= heap_size) break;
                  pick = lft;
                  if (lft + 1 < heap_size && heap_keys[lft + 1] < heap_keys[lft])
                     pick = lft + 1;
                  if (!(heap_keys[pick] < heap_keys[pos])) break;
                  held            = heap_keys[pick];
                  heap_keys[pick] = heap_keys[pos];
                  heap_keys[pos]  = held;
                  pos             = pick;
               end
            end
         end
         bmh_pkg::ACT_PEEK: begin
            if (heap_size == 0) rsp.status = bmh_pkg::ST_EMPTY;
            else rsp.key = heap_keys[0];
         end
         default: ;
      endcase
      rsp.occ = heap_size[OCC_W-1:0];
      return rsp;
   endfunction

   // Favor duplicates and extremes so ties and sign handling get exercised.
   function automatic logic signed [KEY_W-1:0] pick_key();
      logic signed [KEY_W-1:0] key;
      case ($urandom_range(0, 9))
         0, 1: key = int'($urandom_range(0, 8)) - 4;
         2: begin
            case ($urandom_range(0, 3))
               0: key = 32'sh7FFF_FFFF;
               1: key = 32'sh8000_0000;
               2: key = 32'sd0;
               default: key = 32'shFFFF_FFFF;
            endcase
         end
         default: key = $urandom;
      endcase
      return key;
   endfunction

   // Offer one item, hold it until accepted, then log what it owes.
   // Work in bursts: at the end of a burst drop valid for a random gap, which may be empty.
   task automatic send_item(input bmh_pkg::action_type op,
                            input logic signed [KEY_W-1:0] key,
                            input bit typed, input heap_result_type typed_rsp);
      heap_result_type predicted;
      heap_result_type owed;
      int              gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then run a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= op;
      req_chan.key_in <= key;
      do @(posedge clock); while (!req_chan.ready);
      burst_left--;
      predicted  = apply_heap_op(op, key);
      owed       = typed ? typed_rsp : predicted;
      heap_rsp_q = {heap_rsp_q, owed};
   endtask

   // Watchdog: end the run if the traffic never drains.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: check every accepted item against the oldest expectation,
   // then pick the next ready. The stall pattern rotates through always ready, coin
   // flips, random stall runs and a fixed cadence.
   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (heap_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: key %0d status %0d occupancy %0d",
                        rsp_chan.key_out, rsp_chan.status, rsp_chan.occupancy);
         end else begin
            want = heap_rsp_q.pop_front();
            if (rsp_chan.key_out !== want.key || rsp_chan.status !== want.status ||
                rsp_chan.occupancy !== want.occ) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: expected %0d/%s/%0d got %0d/%0d/%0d",
                           want.key, want.status.name(), want.occ,
                           rsp_chan.key_out, rsp_chan.status, rsp_chan.occupancy);
            end
         end
      end
      ready_phase <= ready_phase + 1;
      case ((ready_phase >> 9) % 4)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         2: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_chan.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 10);
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
         default: rsp_chan.ready <= (ready_phase % 3 != 0);
      endcase
   end

   initial begin
      bmh_pkg::action_type op;
      int                  roll;
      // start every input at a known value
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.action = bmh_pkg::ACT_NOP;
      req_chan.key_in = '0;
      rsp_chan.ready  = 1'b0;
      heap_size       = 0;
      mismatch_count  = 0;
      cycle_count     = 0;
      burst_left      = 0;
      stall_left      = 0;
      ready_phase     = 0;
      load_mode       = LOAD_FILL;
      mixed_left      = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_ops[i])
         send_item(directed_ops[i].op, directed_ops[i].key, directed_ops[i].typed,
                   directed_ops[i].rsp);

      // Random part: fill to capacity and push against it, drain to empty and
      // keep removing, with mixed stretches in between.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         case (load_mode)
            LOAD_FILL:
               op = (roll < 80) ? bmh_pkg::ACT_INSERT : (roll < 90) ? bmh_pkg::ACT_PEEK :
                    (roll < 97) ? bmh_pkg::ACT_REMOVE : bmh_pkg::ACT_NOP;
            LOAD_DRAIN:
               op = (roll < 70) ? bmh_pkg::ACT_REMOVE : (roll < 85) ? bmh_pkg::ACT_PEEK :
                    (roll < 95) ? bmh_pkg::ACT_INSERT : bmh_pkg::ACT_NOP;
            default:
               op = (roll < 45) ? bmh_pkg::ACT_INSERT : (roll < 80) ? bmh_pkg::ACT_REMOVE :
                    (roll < 95) ? bmh_pkg::ACT_PEEK : bmh_pkg::ACT_NOP;
         endcase
         send_item(op, pick_key(), 1'b0, '0);

         // advance the traffic shape on the shadow occupancy
         case (load_mode)
            LOAD_FILL:
               if (heap_size == HEAP_DEPTH && $urandom_range(0, 3) == 0)
                  load_mode = LOAD_DRAIN;
            LOAD_DRAIN:
               if (heap_size == 0 && $urandom_range(0, 2) == 0) begin
                  if ($urandom_range(0, 1) == 0) begin
                     load_mode = LOAD_FILL;
                  end else begin
                     load_mode  = LOAD_MIXED;
                     mixed_left = $urandom_range(30, 150);
                  end
               end
            default: begin
               mixed_left--;
               if (mixed_left <= 0) load_mode = LOAD_FILL;
            end
         endcase
      end
      req_chan.valid <= 1'b0;

      // wait for every owed result, then let the pipeline settle
      while (heap_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && heap_rsp_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
